@@ src/tdpd_pkg.sv @@
package tdpd_pkg;

    localparam int PAD_COUNT = 4;
    localparam int POT_COUNT = 2;

    localparam int TOUCH_W  = 16;
    localparam int ADC_W    = 12;
    localparam int LEVEL_W  = 7;
    localparam int CHANGE_W = 8;
    localparam int RUN_W    = 8;
    localparam int PROD_W   = ADC_W + LEVEL_W;

    localparam int LEVEL_SCALE = 127;
    localparam int ADC_FULL    = 4095;

    localparam logic [TOUCH_W-1:0] TOUCH_THRESHOLD_RST = 16'd1000;
    localparam logic [RUN_W-1:0]   DEBOUNCE_COUNT_RST  = 8'd2;
    localparam logic [LEVEL_W-1:0] MOVE_THRESHOLD_RST  = 7'd1;

    typedef logic [1:0] cfg_index_t;
    localparam cfg_index_t CFG_TOUCH_THRESHOLD = 2'd0;
    localparam cfg_index_t CFG_DEBOUNCE_COUNT  = 2'd1;
    localparam cfg_index_t CFG_MOVE_THRESHOLD  = 2'd2;

    typedef struct packed {
        logic [TOUCH_W-1:0] touch_0;
        logic [TOUCH_W-1:0] touch_1;
        logic [TOUCH_W-1:0] touch_2;
        logic [TOUCH_W-1:0] touch_3;
        logic [ADC_W-1:0]   pot_adc_0;
        logic [ADC_W-1:0]   pot_adc_1;
    } tdpd_sample_t;

    typedef struct packed {
        logic [PAD_COUNT-1:0]       pads_held;
        logic [PAD_COUNT-1:0]       pads_pressed;
        logic [LEVEL_W-1:0]         pot_level_0;
        logic [LEVEL_W-1:0]         pot_level_1;
        logic signed [CHANGE_W-1:0] pot_change_0;
        logic signed [CHANGE_W-1:0] pot_change_1;
        logic [POT_COUNT-1:0]       pots_moved;
    } tdpd_result_t;

    // settings shared by the pad lanes; need is debounce count floored at one
    typedef struct packed {
        logic [TOUCH_W-1:0] touch_limit;
        logic [RUN_W-1:0]   need;
    } tdpd_pad_cfg_t;

endpackage

@@ src/tdpd_pad_lane.sv @@
module tdpd_pad_lane (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [tdpd_pkg::TOUCH_W-1:0]    reading,
    input  tdpd_pkg::tdpd_pad_cfg_t         cfg,
    output logic                            held,
    output logic                            pressed
);
    import tdpd_pkg::*;

    logic [RUN_W-1:0] touched_run_reg, touched_run_next;
    logic [RUN_W-1:0] released_run_reg, released_run_next;
    logic             held_reg, held_next;
    logic             raw;

    always_comb
    begin
        raw = reading < cfg.touch_limit;
        if (raw)
        begin
            touched_run_next  = (touched_run_reg < cfg.need) ?
                                touched_run_reg + RUN_W'(1) : touched_run_reg;
            released_run_next = '0;
        end
        else
        begin
            released_run_next = (released_run_reg < cfg.need) ?
                                released_run_reg + RUN_W'(1) : released_run_reg;
            touched_run_next  = '0;
        end
        if (touched_run_next >= cfg.need)
            held_next = 1'b1;
        else if (released_run_next >= cfg.need)
            held_next = 1'b0;
        else
            held_next = held_reg;
        held    = held_next;
        pressed = held_next & ~held_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touched_run_reg  <= '0;
            released_run_reg <= '0;
            held_reg         <= 1'b0;
        end
        else if (en)
        begin
            touched_run_reg  <= touched_run_next;
            released_run_reg <= released_run_next;
            held_reg         <= held_next;
        end
    end

endmodule

@@ src/tdpd_pot_lane.sv @@
module tdpd_pot_lane (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic [tdpd_pkg::ADC_W-1:0]             adc,
    input  logic [tdpd_pkg::LEVEL_W-1:0]           move_threshold,
    output logic [tdpd_pkg::LEVEL_W-1:0]           level,
    output logic signed [tdpd_pkg::CHANGE_W-1:0]   change,
    output logic                                   moved
);
    import tdpd_pkg::*;

    logic [ADC_W-1:0]           avg_reg, avg_next;
    logic [LEVEL_W-1:0]         reported_reg, reported_next;
    logic [ADC_W:0]             sum;
    logic [PROD_W-1:0]          scaled;
    logic [LEVEL_W-1:0]         quot_lo;
    logic [ADC_W:0]             rem;
    logic signed [CHANGE_W-1:0] delta;
    logic [LEVEL_W-1:0]         mag;

    always_comb
    begin
        sum      = {1'b0, avg_reg} + {1'b0, adc};
        avg_next = sum[ADC_W:1];
        scaled   = PROD_W'(avg_next) * PROD_W'(LEVEL_SCALE);
        // divide by 4095: estimate with >>12, one correction step
        quot_lo  = scaled[PROD_W-1:ADC_W];
        rem      = {1'b0, scaled[ADC_W-1:0]} + (ADC_W+1)'(quot_lo);
        level    = quot_lo + LEVEL_W'(rem >= (ADC_W+1)'(ADC_FULL));
        delta    = $signed({1'b0, level}) - $signed({1'b0, reported_reg});
        mag      = delta[CHANGE_W-1] ? LEVEL_W'(-delta) : delta[LEVEL_W-1:0];
        moved    = mag > move_threshold;
        change   = moved ? delta : '0;
        reported_next = moved ? level : reported_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            avg_reg      <= '0;
            reported_reg <= '0;
        end
        else if (en)
        begin
            avg_reg      <= avg_next;
            reported_reg <= reported_next;
        end
    end

endmodule

@@ src/touch_debounce_pot_delta.sv @@
// Touch pad debouncer and pot change detector.
// sample channel (sample_valid/sample_ready/sample): one word per scan tick,
//   four pad readings and two 12-bit pot samples.
// result channel (result_valid/result_ready/result): one word per sample word,
//   debounced held and pressed pad bits, scaled pot levels, signed changes
//   and moved flags.
// cfg channel (cfg_valid/cfg_ready/cfg_index/cfg_data): register writes,
//   always ready; index 0 touch threshold, 1 debounce count, 2 move threshold,
//   index 3 is ignored. Write only while no word is in flight.
// The result word is valid in the cycle after its sample word is taken.
// Throughput: one word per cycle while results are taken; each pad and pot
//   has its own lane whose state update finishes in the accepting cycle, and
//   one output register holds the merged word.
// Stall: while result_valid is high and result_ready low, the result holds
//   and sample_ready drops; it rises again in the cycle the result is taken.
// Reset: registers return to 1000, 2, 1; pads released, runs, averages and
//   reported levels zero; no result pending.
module touch_debounce_pot_delta (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         sample_valid,
    output logic                         sample_ready,
    input  tdpd_pkg::tdpd_sample_t       sample,
    output logic                         result_valid,
    input  logic                         result_ready,
    output tdpd_pkg::tdpd_result_t       result,
    input  logic                         cfg_valid,
    output logic                         cfg_ready,
    input  tdpd_pkg::cfg_index_t         cfg_index,
    input  logic [tdpd_pkg::TOUCH_W-1:0] cfg_data
);
    import tdpd_pkg::*;

    logic [TOUCH_W-1:0] touch_limit_reg;
    logic [RUN_W-1:0]   debounce_count_reg;
    logic [LEVEL_W-1:0] move_threshold_reg;

    tdpd_pad_cfg_t      pad_cfg;
    logic               accept;
    logic               result_valid_reg, result_valid_next;
    tdpd_result_t       result_reg, result_next;

    logic [TOUCH_W-1:0]         touch_w [PAD_COUNT];
    logic [ADC_W-1:0]           adc_w [POT_COUNT];
    logic [PAD_COUNT-1:0]       held_w, pressed_w;
    logic [LEVEL_W-1:0]         level_w [POT_COUNT];
    logic signed [CHANGE_W-1:0] change_w [POT_COUNT];
    logic [POT_COUNT-1:0]       moved_w;

    assign cfg_ready    = 1'b1;
    assign accept       = sample_valid && sample_ready;
    assign sample_ready = !result_valid_reg || result_ready;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            touch_limit_reg     <= TOUCH_THRESHOLD_RST;
            debounce_count_reg  <= DEBOUNCE_COUNT_RST;
            move_threshold_reg  <= MOVE_THRESHOLD_RST;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                CFG_TOUCH_THRESHOLD: touch_limit_reg     <= cfg_data;
                CFG_DEBOUNCE_COUNT:  debounce_count_reg  <= cfg_data[RUN_W-1:0];
                CFG_MOVE_THRESHOLD:  move_threshold_reg  <= cfg_data[LEVEL_W-1:0];
                default: ;
            endcase
        end
    end

    assign pad_cfg.touch_limit = touch_limit_reg;
    assign pad_cfg.need = (debounce_count_reg == '0) ? RUN_W'(1) : debounce_count_reg;

    assign touch_w[0] = sample.touch_0;
    assign touch_w[1] = sample.touch_1;
    assign touch_w[2] = sample.touch_2;
    assign touch_w[3] = sample.touch_3;
    assign adc_w[0]   = sample.pot_adc_0;
    assign adc_w[1]   = sample.pot_adc_1;

    for (genvar i = 0; i < PAD_COUNT; i++)
    begin : g_pad
        tdpd_pad_lane u_pad (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (accept),
            .reading (touch_w[i]),
            .cfg     (pad_cfg),
            .held    (held_w[i]),
            .pressed (pressed_w[i])
        );
    end

    for (genvar i = 0; i < POT_COUNT; i++)
    begin : g_pot
        tdpd_pot_lane u_pot (
            .clk            (clk),
            .rst_n          (rst_n),
            .en             (accept),
            .adc            (adc_w[i]),
            .move_threshold (move_threshold_reg),
            .level          (level_w[i]),
            .change         (change_w[i]),
            .moved          (moved_w[i])
        );
    end

    // merge lanes into one result word and work out the next result valid
    always_comb
    begin
        result_next.pads_held    = held_w;
        result_next.pads_pressed = pressed_w;
        result_next.pot_level_0  = level_w[0];
        result_next.pot_level_1  = level_w[1];
        result_next.pot_change_0 = change_w[0];
        result_next.pot_change_1 = change_w[1];
        result_next.pots_moved   = moved_w;

        if (accept)
            result_valid_next = 1'b1;
        else if (result_ready)
            result_valid_next = 1'b0;
        else
            result_valid_next = result_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else
            result_valid_reg <= result_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            result_reg <= result_next;
    end

`ifndef NO_ASSERTIONS
    a_pressed_implies_held: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> ((result.pads_pressed & ~result.pads_held) == '0))
        else $error("pressed pad not held");

    a_moved_0_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pots_moved[0] == (result.pot_change_0 != '0)))
        else $error("pot 0 moved flag disagrees with change");

    a_moved_1_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (result.pots_moved[1] == (result.pot_change_1 != '0)))
        else $error("pot 1 moved flag disagrees with change");

    a_accept_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> result_valid)
        else $error("accepted word produced no result");
`endif

endmodule

@@ bench/tdpd_scan_checker.sv @@
module tdpd_scan_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          sample_valid,
    input  logic                          sample_ready,
    input  tdpd_pkg::tdpd_sample_t        sample,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  tdpd_pkg::tdpd_result_t        result,
    input  logic                          cfg_valid,
    input  logic                          cfg_ready,
    input  tdpd_pkg::cfg_index_t          cfg_index,
    input  logic [tdpd_pkg::TOUCH_W-1:0]  cfg_data,
    output int                            owed_count,
    output int                            mismatch_count
);
    timeunit 1ns;
    timeprecision 1ps;

    import tdpd_pkg::*;

    logic [TOUCH_W-1:0] touch_thr;
    logic [RUN_W-1:0]   db_count;
    logic [LEVEL_W-1:0] move_thr;

    logic [PAD_COUNT-1:0] pad_on;
    int                   touched_run [PAD_COUNT];
    int                   released_run [PAD_COUNT];
    int                   pot_avg [POT_COUNT];
    int                   pot_rep [POT_COUNT];

    tdpd_result_t scan_results_due [$];

    task automatic note_error(input string msg);
        mismatch_count++;
        if (mismatch_count <= 40)
            $display("%0t ns: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
            note_error($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    function automatic tdpd_result_t next_scan_result(input tdpd_sample_t s);
        tdpd_result_t       r;
        logic [TOUCH_W-1:0] rd [PAD_COUNT];
        logic [ADC_W-1:0]   adc [POT_COUNT];
        int                 lvl [POT_COUNT];
        int                 chg [POT_COUNT];
        int                 need, avg, dlt, mag, i;
        logic               now;
        rd[0] = s.touch_0;
        rd[1] = s.touch_1;
        rd[2] = s.touch_2;
        rd[3] = s.touch_3;
        adc[0] = s.pot_adc_0;
        adc[1] = s.pot_adc_1;
        need = (db_count == 0) ? 1 : int'(db_count);
        r = '0;
        for (i = 0; i < PAD_COUNT; i++)
        begin
            if (rd[i] < touch_thr)
            begin
                if (touched_run[i] < need)
                    touched_run[i]++;
                released_run[i] = 0;
            end
            else
            begin
                if (released_run[i] < need)
                    released_run[i]++;
                touched_run[i] = 0;
            end
            now = pad_on[i];
            if (touched_run[i] >= need)
                now = 1'b1;
            else if (released_run[i] >= need)
                now = 1'b0;
            r.pads_pressed[i] = now & ~pad_on[i];
            r.pads_held[i] = now;
            pad_on[i] = now;
        end
        for (i = 0; i < POT_COUNT; i++)
        begin
            avg = (pot_avg[i] + int'(adc[i])) >> 1;
            lvl[i] = avg * LEVEL_SCALE / ADC_FULL;
            dlt = lvl[i] - pot_rep[i];
            mag = (dlt < 0) ? -dlt : dlt;
            pot_avg[i] = avg;
            chg[i] = 0;
            if (mag > int'(move_thr))
            begin
                chg[i] = dlt;
                pot_rep[i] = lvl[i];
                r.pots_moved[i] = 1'b1;
            end
        end
        r.pot_level_0 = lvl[0][LEVEL_W-1:0];
        r.pot_level_1 = lvl[1][LEVEL_W-1:0];
        r.pot_change_0 = chg[0][CHANGE_W-1:0];
        r.pot_change_1 = chg[1][CHANGE_W-1:0];
        return r;
    endfunction

    initial mismatch_count = 0;

    always @(posedge clk or negedge rst_n)
    begin
        tdpd_result_t want;
        if (!rst_n)
        begin
            touch_thr = TOUCH_THRESHOLD_RST;
            db_count = DEBOUNCE_COUNT_RST;
            move_thr = MOVE_THRESHOLD_RST;
            pad_on = '0;
            for (int i = 0; i < PAD_COUNT; i++)
            begin
                touched_run[i] = 0;
                released_run[i] = 0;
            end
            for (int i = 0; i < POT_COUNT; i++)
            begin
                pot_avg[i] = 0;
                pot_rep[i] = 0;
            end
            scan_results_due.delete();
            owed_count <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_TOUCH_THRESHOLD: touch_thr = cfg_data;
                    CFG_DEBOUNCE_COUNT:  db_count = cfg_data[RUN_W-1:0];
                    CFG_MOVE_THRESHOLD:  move_thr = cfg_data[LEVEL_W-1:0];
                    default: ;
                endcase
            end
            // result taken this edge belongs to an earlier sample word
            if (result_valid && result_ready)
            begin
                if (scan_results_due.size() == 0)
                    note_error("result word with nothing owed");
                else
                begin
                    want = scan_results_due.pop_front();
                    check_field("pads_held", int'(result.pads_held),
                                int'(want.pads_held));
                    check_field("pads_pressed", int'(result.pads_pressed),
                                int'(want.pads_pressed));
                    check_field("pot_level_0", int'(result.pot_level_0),
                                int'(want.pot_level_0));
                    check_field("pot_level_1", int'(result.pot_level_1),
                                int'(want.pot_level_1));
                    check_field("pot_change_0", int'(result.pot_change_0),
                                int'(want.pot_change_0));
                    check_field("pot_change_1", int'(result.pot_change_1),
                                int'(want.pot_change_1));
                    check_field("pots_moved", int'(result.pots_moved),
                                int'(want.pots_moved));
                end
            end
            if (sample_valid && sample_ready)
                scan_results_due.push_back(next_scan_result(sample));
            owed_count <= scan_results_due.size();
        end
    end

endmodule

@@ bench/touch_debounce_pot_delta_tb.sv @@
module touch_debounce_pot_delta_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdpd_pkg::*;

    localparam cfg_index_t CFG_UNUSED = 2'd3;
    localparam int PHASES = 11;
    localparam int PHASE_WORDS = 150;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               sample_valid;
    logic               sample_ready;
    tdpd_sample_t       sample;
    logic               result_valid;
    logic               result_ready;
    tdpd_result_t       result;
    logic               cfg_valid;
    logic               cfg_ready;
    cfg_index_t         cfg_index;
    logic [TOUCH_W-1:0] cfg_data;
    int                 owed_count;
    int                 mismatch_count;

    bit                 pace_on = 1'b1;
    int                 long_hold = 0;
    logic [TOUCH_W-1:0] cur_thr = TOUCH_THRESHOLD_RST;
    bit                 want_touch [PAD_COUNT];
    int                 pot_pos [POT_COUNT];

    always #2 clk = ~clk;

    touch_debounce_pot_delta uut (.*);

    tdpd_scan_checker scan_check (.*);

    function automatic int idle_gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
    endfunction

    function automatic logic [TOUCH_W-1:0] pad_reading(input bit touched);
        if (touched && cur_thr != 0)
        begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return cur_thr - 1'b1;
                default: return 16'($urandom_range(0, int'(cur_thr) - 1));
            endcase
        end
        case ($urandom_range(0, 3))
            0: return cur_thr;
            1: return '1;
            default: return 16'($urandom_range(int'(cur_thr), 65535));
        endcase
    endfunction

    function automatic tdpd_sample_t random_scan();
        tdpd_sample_t       w;
        logic [TOUCH_W-1:0] rd [PAD_COUNT];
        logic [ADC_W-1:0]   adc [POT_COUNT];
        int                 i;
        for (i = 0; i < PAD_COUNT; i++)
        begin
            if ($urandom_range(0, 19) == 0)
                want_touch[i] = !want_touch[i];
            if ($urandom_range(0, 19) == 0)
                rd[i] = 16'($urandom_range(0, 65535));
            else
                rd[i] = pad_reading(($urandom_range(0, 9) == 0) ? !want_touch[i]
                                                                 : want_touch[i]);
        end
        for (i = 0; i < POT_COUNT; i++)
        begin
            case ($urandom_range(0, 9))
                0: pot_pos[i] = $urandom_range(0, ADC_FULL);
                1: pot_pos[i] = ($urandom_range(0, 1) == 0) ? 0 : ADC_FULL;
                default: pot_pos[i] = pot_pos[i] + int'($urandom_range(0, 400)) - 200;
            endcase
            if (pot_pos[i] < 0)
                pot_pos[i] = 0;
            if (pot_pos[i] > ADC_FULL)
                pot_pos[i] = ADC_FULL;
            adc[i] = pot_pos[i][ADC_W-1:0];
        end
        w.touch_0 = rd[0];
        w.touch_1 = rd[1];
        w.touch_2 = rd[2];
        w.touch_3 = rd[3];
        w.pot_adc_0 = adc[0];
        w.pot_adc_1 = adc[1];
        return w;
    endfunction

    // valid stays up across back-to-back words; dropped only for a gap
    task automatic push_word(input tdpd_sample_t w);
        int gap;
        gap = (pace_on && $urandom_range(0, 3) == 0) ? idle_gap_len() : 0;
        if (gap > 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample <= w;
        sample_valid <= 1'b1;
        do @(posedge clk); while (!sample_ready);
    endtask

    task automatic drive_scan(input logic [TOUCH_W-1:0] p0, p1, p2, p3,
                              input logic [ADC_W-1:0] a0, a1);
        tdpd_sample_t w;
        w.touch_0 = p0;
        w.touch_1 = p1;
        w.touch_2 = p2;
        w.touch_3 = p3;
        w.pot_adc_0 = a0;
        w.pot_adc_1 = a1;
        push_word(w);
    endtask

    task automatic settle();
        sample_valid <= 1'b0;
        do @(posedge clk); while (owed_count != 0);
        repeat (2) @(posedge clk);
    endtask

    task automatic write_reg(input cfg_index_t idx, input logic [TOUCH_W-1:0] d);
        settle();
        cfg_index <= idx;
        cfg_data <= d;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == CFG_TOUCH_THRESHOLD)
            cur_thr = d;
    endtask

    task automatic setup_phase(input int ph);
        logic [TOUCH_W-1:0] thr;
        logic [RUN_W-1:0]   db;
        logic [LEVEL_W-1:0] mv;
        case (ph)
            0:
            begin
                thr = TOUCH_THRESHOLD_RST;
                db = DEBOUNCE_COUNT_RST;
                mv = MOVE_THRESHOLD_RST;
            end
            1:
            begin
                thr = '0;
                db = '0;
                mv = '0;
            end
            2:
            begin
                thr = '1;
                db = 8'd1;
                mv = 7'd127;
            end
            3:
            begin
                thr = 16'($urandom_range(200, 3000));
                db = 8'd255;
                mv = 7'($urandom_range(0, 127));
            end
            4:
            begin
                thr = 16'($urandom_range(200, 3000));
                db = 8'd1;
                mv = '0;
            end
            default:
            begin
                thr = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(200, 3000));
                db = ($urandom_range(0, 4) == 0) ? 8'($urandom) : 8'($urandom_range(0, 6));
                mv = ($urandom_range(0, 3) == 0) ? 7'($urandom) : 7'($urandom_range(0, 8));
            end
        endcase
        write_reg(CFG_TOUCH_THRESHOLD, thr);
        write_reg(CFG_DEBOUNCE_COUNT, {8'($urandom), db});
        write_reg(CFG_MOVE_THRESHOLD, {9'($urandom), mv});
        if (ph == 1 || $urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, 16'($urandom));
    endtask

    initial
    begin : result_sink
        int stall_left;
        stall_left = 0;
        result_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (long_hold > 0)
            begin
                stall_left = long_hold;
                long_hold = 0;
            end
            else if (stall_left == 0 && pace_on && $urandom_range(0, 3) == 0)
                stall_left = idle_gap_len();
            if (stall_left > 0)
            begin
                result_ready <= 1'b0;
                stall_left--;
            end
            else
                result_ready <= 1'b1;
        end
    end

    initial
    begin
        #4_000_000;
        $display("touch_debounce_pot_delta_tb NOT OK");
        $finish;
    end

    initial
    begin
        rst_n <= 1'b0;
        sample_valid <= 1'b0;
        sample <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= CFG_TOUCH_THRESHOLD;
        cfg_data <= '0;
        for (int i = 0; i < PAD_COUNT; i++)
            want_touch[i] = 1'b0;
        for (int i = 0; i < POT_COUNT; i++)
            pot_pos[i] = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: threshold edges, debounce runs, pot extremes
        drive_scan(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 12'h000, 12'h000);
        drive_scan(16'd0, 16'd0, 16'd0, 16'd0, 12'hFFF, 12'hFFF);
        drive_scan(16'd999, 16'd999, 16'd999, 16'd999, 12'hFFF, 12'hFFF);
        drive_scan(16'd1000, 16'd1000, 16'd1000, 16'd1000, 12'hFFF, 12'h000);
        drive_scan(16'd0, 16'd999, 16'd0, 16'd999, 12'hFFF, 12'h000);
        drive_scan(16'd1000, 16'hFFFF, 16'd1000, 16'hFFFF, 12'h000, 12'hFFF);
        drive_scan(16'hFFFF, 16'd1000, 16'hFFFF, 16'd1000, 12'h000, 12'hFFF);
        drive_scan(16'd0, 16'hFFFF, 16'd999, 16'd1000, 12'h000, 12'h000);
        drive_scan(16'd0, 16'hFFFF, 16'd999, 16'd1000, 12'd800, 12'd800);
        drive_scan(16'hAAAA, 16'h5555, 16'hAAAA, 16'h5555, 12'hAAA, 12'h555);
        drive_scan(16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 12'h555, 12'hAAA);
        drive_scan(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 12'd33, 12'd32);
        drive_scan(16'd0, 16'd0, 16'hFFFF, 16'hFFFF, 12'd34, 12'd66);
        repeat (3) drive_scan(16'd5, 16'd5000, 16'd5, 16'd5000, 12'hFFF, 12'hFFF);
        repeat (3) drive_scan(16'd5000, 16'd5, 16'd5000, 16'd5, 12'h000, 12'h000);
        drive_scan(16'd1, 16'd998, 16'd1001, 16'hFFFE, 12'd1, 12'd4094);

        for (int ph = 0; ph < PHASES; ph++)
        begin
            setup_phase(ph);
            pace_on = (ph % 5 != 0);
            for (int n = 0; n < PHASE_WORDS; n++)
            begin
                if (ph == 3 && n == 40)
                    long_hold = 300;
                push_word(random_scan());
            end
        end

        pace_on = 1'b0;
        sample_valid <= 1'b0;
        do @(posedge clk); while (owed_count != 0);
        repeat (4) @(posedge clk);
        if (mismatch_count == 0)
            $display("touch_debounce_pot_delta_tb OK");
        else
            $display("touch_debounce_pot_delta_tb NOT OK");
        $finish;
    end

endmodule

@@ filelist.f @@
src/tdpd_pkg.sv
src/tdpd_pad_lane.sv
src/tdpd_pot_lane.sv
src/touch_debounce_pot_delta.sv
bench/tdpd_scan_checker.sv
bench/touch_debounce_pot_delta_tb.sv
